// File: sv/fqsr_pkg.sv
package fqsr_pkg;

  // Field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 5;

  // Packed channel widths, rounded up to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   word_t;
  typedef logic [CNT_W-1:0]    cnt5_t;

  // Operation codes
  localparam op_t OP_ENQUEUE    = 3'd0;
  localparam op_t OP_DEQUEUE    = 3'd1;
  localparam op_t OP_PEEK_FRONT = 3'd2;
  localparam op_t OP_PEEK_REAR  = 3'd3;
  localparam op_t OP_SIZE       = 3'd4;
  localparam op_t OP_SEARCH     = 3'd5;
  localparam op_t OP_REVERSE    = 3'd6;
  localparam op_t OP_CLEAR      = 3'd7;

  // Status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // Word returned by a read of an empty queue
  localparam word_t EMPTY_WORD = 32'h8000_0000;

endpackage

// File: sv/fqsr_ram.sv
module fqsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/fifo_queue_search_reverse.sv
// Sequence: size, enqueue, reverse, clear and the empty/full cases go from accept to S_FIN
// and then the output register; dequeue and peeks pass S_RD first (registered store read),
// and search passes S_SRCH, which compares one stored entry per cycle.
// One item in flight: the next item is accepted once the result has entered the output
// register, and a result waiting on out_tready holds the input off.
// Reset (rst_n low, synchronous) empties the queue, restores normal order, drops any result.
module fifo_queue_search_reverse #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] operation, [34:3] value, [39:35] zero
  input  logic [fqsr_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] data_out, [33:32] status, [38:34] position, [43:39] occupancy, [47:44] zero
  output logic [fqsr_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  import fqsr_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Step a physical slot forward with wrap
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
  endfunction

  // Step a physical slot backward with wrap
  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
  endfunction

  // Slot at an offset below twice the capacity
  function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] f, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(f) + SW'(c);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  // Keep the low bits of a count for the result fields
  function automatic cnt5_t low5(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[CNT_W-1:0];
  endfunction

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] cmp_r, cmp_nxt;
  word_t         key_r, key_nxt;

  word_t         res_data_r, res_data_nxt;
  status_t       res_status_r, res_status_nxt;
  cnt5_t         res_pos_r, res_pos_nxt;
  cnt5_t         res_occ_r, res_occ_nxt;

  logic          out_valid_r, out_valid_nxt;
  word_t         out_data_r, out_data_nxt;
  status_t       out_status_r, out_status_nxt;
  cnt5_t         out_pos_r, out_pos_nxt;
  cnt5_t         out_occ_r, out_occ_nxt;

  logic          in_accept;
  op_t           in_op;
  word_t         in_value;
  logic          empty;
  logic [AW-1:0] rear_slot;
  logic [AW-1:0] head_slot;
  logic [AW-1:0] tail_slot;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  word_t         ram_rdata;

  assign in_op     = in_tdata[OP_W-1:0];
  assign in_value  = in_tdata[OP_W +: DATA_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign empty     = (count_r == '0);

  // Logical front and rear in physical slots
  assign rear_slot = add_wrap(front_r, count_r - CW'(1));
  assign head_slot = rev_r ? rear_slot : front_r;
  assign tail_slot = rev_r ? front_r : rear_slot;

  fqsr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and queue state
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    rev_nxt        = rev_r;
    ptr_nxt        = ptr_r;
    cmp_nxt        = cmp_r;
    key_nxt        = key_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_occ_nxt    = res_occ_r;
    ram_we         = 1'b0;
    ram_waddr      = rev_r ? wrap_dec(front_r) : add_wrap(front_r, count_r);
    ram_raddr      = head_slot;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_data_nxt   = '0;
          res_status_nxt = ST_OK;
          res_pos_nxt    = '0;
          state_nxt      = S_FIN;
          unique case (in_op)
            OP_ENQUEUE: begin
              if (count_r >= CW'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                if (rev_r) begin
                  front_nxt = wrap_dec(front_r);
                end
              end
            end
            OP_DEQUEUE: begin
              if (empty) begin
                res_data_nxt   = EMPTY_WORD;
                res_status_nxt = ST_EMPTY;
              end else begin
                ram_raddr = head_slot;
                count_nxt = count_r - CW'(1);
                if (!rev_r) begin
                  front_nxt = wrap_inc(front_r);
                end
                state_nxt = S_RD;
              end
            end
            OP_PEEK_FRONT, OP_PEEK_REAR: begin
              if (empty) begin
                res_data_nxt   = EMPTY_WORD;
                res_status_nxt = ST_EMPTY;
              end else begin
                ram_raddr = (in_op == OP_PEEK_FRONT) ? head_slot : tail_slot;
                state_nxt = S_RD;
              end
            end
            OP_SIZE: begin
            end
            OP_SEARCH: begin
              if (empty) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                // Issue the front entry, then walk one slot per cycle
                ram_raddr = head_slot;
                ptr_nxt   = rev_r ? wrap_dec(head_slot) : wrap_inc(head_slot);
                cmp_nxt   = '0;
                key_nxt   = in_value;
                state_nxt = S_SRCH;
              end
            end
            OP_REVERSE: begin
              rev_nxt = !rev_r;
            end
            OP_CLEAR: begin
              count_nxt = '0;
              front_nxt = '0;
              rev_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
          res_occ_nxt = low5(count_nxt);
        end
      end
      S_RD: begin
        res_data_nxt = ram_rdata;
        state_nxt    = S_FIN;
      end
      S_SRCH: begin
        // Compare the entry read last cycle; fetch the next one meanwhile
        ram_raddr = ptr_r;
        ptr_nxt   = rev_r ? wrap_dec(ptr_r) : wrap_inc(ptr_r);
        cmp_nxt   = cmp_r + CW'(1);
        if (ram_rdata == key_r) begin
          res_status_nxt = ST_OK;
          res_pos_nxt    = low5(cmp_r + CW'(1));
          state_nxt      = S_FIN;
        end else if (cmp_r + CW'(1) == count_r) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load the finished result, drop it when taken
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_occ_nxt    = out_occ_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = res_data_r;
      out_status_nxt = res_status_r;
      out_pos_nxt    = res_pos_r;
      out_occ_nxt    = res_occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    cmp_r        <= cmp_nxt;
    key_r        <= key_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_occ_r    <= res_occ_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_occ_r, out_pos_r, out_status_r, out_data_r};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(front_r) < SW'(CAPACITY))
    else $error("front slot out of range");

  a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> count_r != '0 && cmp_r < count_r)
    else $error("search walked past the stored entries");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_op == OP_CLEAR |=> count_r == '0 && !rev_r && res_occ_r == '0)
    else $error("clear left entries behind");
`endif

endmodule
